// ===== rtl/core/checksummed_i2c_frame_sequencer_top_macros.svh =====
// assertion macros for the checksummed i2c frame sequencer
// used by checksummed_i2c_frame_sequencer_top; expects clk and rst_n in scope
`ifndef CHECKSUMMED_I2C_FRAME_SEQUENCER_TOP_MACROS_SVH
`define CHECKSUMMED_I2C_FRAME_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CSI2C_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CSI2C_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/csi2c_pkg.sv =====
// shared types, codes and greeting rom for the checksummed i2c frame sequencer
// no dependencies
package csi2c_pkg;

  localparam int STORE_DEPTH = 32;
  localparam int IDX_W       = 5;
  localparam int LEN_W       = 6;

  // action codes of an input transaction
  localparam logic [1:0] ACT_REQUEST  = 2'd0;
  localparam logic [1:0] ACT_TX_READY = 2'd1;
  localparam logic [1:0] ACT_RX_BYTE  = 2'd2;
  localparam logic [1:0] ACT_LOAD     = 2'd3;

  // link phase codes
  localparam logic [2:0] PH_GREET_PEND = 3'd0;
  localparam logic [2:0] PH_WRITE_PEND = 3'd1;
  localparam logic [2:0] PH_WRITING    = 3'd2;
  localparam logic [2:0] PH_READ_PEND  = 3'd3;
  localparam logic [2:0] PH_READING    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_TX_LENGTH      = 2'd1;
  localparam logic [1:0] CFG_RX_LENGTH      = 2'd2;

  localparam logic [7:0] SUM_GOOD = 8'hFF;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       start_write;
    logic       start_read;
    logic [6:0] bus_address;
    logic       send_stop;
    logic       rx_valid;
    logic [4:0] rx_index;
    logic [7:0] rx_byte;
    logic       frame_done;
    logic       checksum_error;
    logic [2:0] phase;
  } result_t;

  typedef struct packed {
    logic             load_en;
    logic [IDX_W-1:0] load_idx;
    logic [7:0]       load_data;
    logic             snap_en;
    logic [IDX_W-1:0] rd_idx;
  } store_ctl_t;

  function automatic logic [7:0] greeting_rom(input logic [5:0] pos);
    logic [7:0] b;
    case (pos)
      6'd0:  b = 8'hCC;  6'd1:  b = 8'h4C;  6'd2:  b = 8'h65;  6'd3:  b = 8'h74;
      6'd4:  b = 8'h27;  6'd5:  b = 8'h73;  6'd6:  b = 8'h20;  6'd7:  b = 8'h73;
      6'd8:  b = 8'h61;  6'd9:  b = 8'h6D;  6'd10: b = 8'h62;  6'd11: b = 8'h61;
      6'd12: b = 8'h20;  6'd13: b = 8'h6E;  6'd14: b = 8'h78;  6'd15: b = 8'h74;
      6'd16: b = 8'h20;  6'd17: b = 8'h61;  6'd18: b = 8'h72;  6'd19: b = 8'h6D;
      6'd20: b = 8'h20;  6'd21: b = 8'h69;  6'd22: b = 8'h6E;  6'd23: b = 8'h20;
      6'd24: b = 8'h61;  6'd25: b = 8'h72;  6'd26: b = 8'h6D;  6'd27: b = 8'h2C;
      6'd28: b = 8'h20;  6'd29: b = 8'h28;  6'd30: b = 8'h63;  6'd31: b = 8'h29;
      6'd32: b = 8'h4C;  6'd33: b = 8'h45;  6'd34: b = 8'h47;  6'd35: b = 8'h4F;
      6'd36: b = 8'h20;  6'd37: b = 8'h53;  6'd38: b = 8'h79;  6'd39: b = 8'h73;
      6'd40: b = 8'h74;  6'd41: b = 8'h65;  6'd42: b = 8'h6D;  6'd43: b = 8'h20;
      6'd44: b = 8'h41;  6'd45: b = 8'h2F;  6'd46: b = 8'h53;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/checksummed_i2c_frame_sequencer_top.sv =====
// top level of the checksummed i2c frame sequencer: input register, result register,
// configuration registers; depends on csi2c_pkg, csi2c_engine, csi2c_store and the macros header
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_stall   | action, nack_seen, data_byte, payload_index
//   out_    | output    | out_valid / out_stall | tx, start, address, stop, rx, done, error, phase
//   cfg_    | input     | cfg_we                | cfg_index, cfg_data
//
// one transaction per cycle sustained while out_stall is low; a transaction passes from input to result
// through the input register, then single-pass step logic into the result register
// rst_n is synchronous: phases go to greeting pending, payload store clears to zero,
// configuration returns to address 1, tx length 8, rx length 12
// a stalled result holds in the result register while one more transaction waits in the
// input register; in_stall rises only when both are full and out_stall is high
module checksummed_i2c_frame_sequencer_top #(
  parameter int MAX_TX_BYTES   = 32,
  parameter int MAX_RX_BYTES   = 32,
  parameter int GREETING_BYTES = 47
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration write port
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic       in_nack_seen,
  input  logic [7:0] in_data_byte,
  input  logic [4:0] in_payload_index,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_start_write,
  output logic       out_start_read,
  output logic [6:0] out_bus_address,
  output logic       out_send_stop,
  output logic       out_rx_valid,
  output logic [4:0] out_rx_index,
  output logic [7:0] out_rx_byte,
  output logic       out_frame_done,
  output logic       out_checksum_error,
  output logic [2:0] out_phase
);

  // configuration registers
  logic [6:0] dev_addr_r;
  logic [5:0] tx_len_r;
  logic [5:0] rx_len_r;

  // input register
  logic       item_valid_r;
  logic [1:0] action_r;
  logic       nack_r;
  logic [7:0] data_r;
  logic [4:0] pidx_r;

  // result register
  logic               out_valid_r;
  csi2c_pkg::result_t out_r;

  csi2c_pkg::result_t    res;
  csi2c_pkg::store_ctl_t ctl;
  logic [7:0]            pay0;
  logic [7:0]            rd_data;
  logic                  advance;
  logic                  fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 7'd1;
      tx_len_r   <= 6'd8;
      rx_len_r   <= 6'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        csi2c_pkg::CFG_DEVICE_ADDRESS: dev_addr_r <= cfg_data;
        csi2c_pkg::CFG_TX_LENGTH:      tx_len_r   <= cfg_data[5:0];
        csi2c_pkg::CFG_RX_LENGTH:      rx_len_r   <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // result register is free when empty or being taken this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = item_valid_r && advance;
  assign in_stall = item_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid_r <= 1'b1;
    end else if (fire) begin
      item_valid_r <= 1'b0;
    end
  end

  // payload of the input register
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      action_r <= in_action;
      nack_r   <= in_nack_seen;
      data_r   <= in_data_byte;
      pidx_r   <= in_payload_index;
    end
  end

  csi2c_engine #(
    .MAX_TX_BYTES   (MAX_TX_BYTES),
    .MAX_RX_BYTES   (MAX_RX_BYTES),
    .GREETING_BYTES (GREETING_BYTES)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .action         (action_r),
    .nack_seen      (nack_r),
    .data_byte      (data_r),
    .payload_index  (pidx_r),
    .device_address (dev_addr_r),
    .tx_length      (tx_len_r),
    .rx_length      (rx_len_r),
    .pay0           (pay0),
    .rd_data        (rd_data),
    .ctl            (ctl),
    .res            (res)
  );

  csi2c_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .pay0    (pay0),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tx_valid       = out_r.tx_valid;
  assign out_tx_byte        = out_r.tx_byte;
  assign out_start_write    = out_r.start_write;
  assign out_start_read     = out_r.start_read;
  assign out_bus_address    = out_r.bus_address;
  assign out_send_stop      = out_r.send_stop;
  assign out_rx_valid       = out_r.rx_valid;
  assign out_rx_index       = out_r.rx_index;
  assign out_rx_byte        = out_r.rx_byte;
  assign out_frame_done     = out_r.frame_done;
  assign out_checksum_error = out_r.checksum_error;
  assign out_phase          = out_r.phase;

`include "checksummed_i2c_frame_sequencer_top_macros.svh"

  // a write start always carries the first byte and leaves the link writing
  `CSI2C_ASSERT_NOW(a_start_write_phase, out_valid_r && out_r.start_write, out_r.tx_valid && out_r.phase == csi2c_pkg::PH_WRITING, "start_write without first byte or writing phase")

  // received payload bytes only while reading
  `CSI2C_ASSERT_NOW(a_rx_in_reading, out_valid_r && out_r.rx_valid, out_r.phase == csi2c_pkg::PH_READING, "rx byte outside reading phase")

  // checksum errors are only flagged at frame end
  `CSI2C_ASSERT_NOW(a_err_with_done, out_valid_r && out_r.checksum_error, out_r.frame_done, "checksum_error without frame_done")

  // a waiting transaction is not dropped while the result is stalled
  `CSI2C_ASSERT_NEXT(a_item_held, item_valid_r && out_valid_r && out_stall, item_valid_r, "pending transaction lost under stall")

endmodule

// ===== rtl/core/csi2c_store.sv =====
// payload store and per-frame snapshot registers
// depends on csi2c_pkg
module csi2c_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csi2c_pkg::store_ctl_t  ctl,
  output logic [7:0]             pay0,
  output logic [7:0]             rd_data
);

  logic [7:0] payload_r [csi2c_pkg::STORE_DEPTH];
  logic [7:0] snap_r    [csi2c_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < csi2c_pkg::STORE_DEPTH; i++) begin
        payload_r[i] <= 8'h00;
      end
    end else if (ctl.load_en) begin
      payload_r[ctl.load_idx] <= ctl.load_data;
    end
  end

  // whole-store copy at write frame start
  always_ff @(posedge clk) begin
    if (ctl.snap_en) begin
      for (int i = 0; i < csi2c_pkg::STORE_DEPTH; i++) begin
        snap_r[i] <= payload_r[i];
      end
    end
  end

  assign pay0    = payload_r[0];
  assign rd_data = snap_r[ctl.rd_idx];

endmodule

// ===== rtl/core/csi2c_engine.sv =====
// frame sequencing state and per-transaction result logic
// depends on csi2c_pkg
module csi2c_engine #(
  parameter int MAX_TX_BYTES   = 32,
  parameter int MAX_RX_BYTES   = 32,
  parameter int GREETING_BYTES = 47
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [1:0]            action,
  input  logic                  nack_seen,
  input  logic [7:0]            data_byte,
  input  logic [4:0]            payload_index,
  input  logic [6:0]            device_address,
  input  logic [5:0]            tx_length,
  input  logic [5:0]            rx_length,
  input  logic [7:0]            pay0,
  input  logic [7:0]            rd_data,
  output csi2c_pkg::store_ctl_t ctl,
  output csi2c_pkg::result_t    res
);

  localparam int TX_LIM    = (MAX_TX_BYTES < csi2c_pkg::STORE_DEPTH) ?
                             MAX_TX_BYTES : csi2c_pkg::STORE_DEPTH;
  localparam int RX_LIM    = (MAX_RX_BYTES < csi2c_pkg::STORE_DEPTH) ?
                             MAX_RX_BYTES : csi2c_pkg::STORE_DEPTH;
  localparam int LONGEST   = (GREETING_BYTES > csi2c_pkg::STORE_DEPTH) ?
                             GREETING_BYTES : csi2c_pkg::STORE_DEPTH;
  // position runs one past the frame length
  localparam int POS_W     = $clog2(LONGEST + 2);

  localparam logic [csi2c_pkg::LEN_W-1:0] TX_LIM_V = csi2c_pkg::LEN_W'(TX_LIM);
  localparam logic [csi2c_pkg::LEN_W-1:0] RX_LIM_V = csi2c_pkg::LEN_W'(RX_LIM);
  localparam logic [POS_W-1:0]            GREET_LEN = POS_W'(GREETING_BYTES);

  logic [2:0]       phase_r, phase_nxt;
  logic [2:0]       after_r, after_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] flen_r, flen_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic             dummy_r, dummy_nxt;
  logic             gsrc_r, gsrc_nxt;

  logic [csi2c_pkg::LEN_W-1:0] tx_eff, rx_eff;
  logic [POS_W-1:0]            prev_pos, rd_pos;
  logic [7:0]                  fbyte, lead_byte, rx_total;
  logic                        greet;

  always_comb begin
    if (tx_length == '0) begin
      tx_eff = csi2c_pkg::LEN_W'(1);
    end else if (tx_length > TX_LIM_V) begin
      tx_eff = TX_LIM_V;
    end else begin
      tx_eff = tx_length;
    end
    if (rx_length == '0) begin
      rx_eff = csi2c_pkg::LEN_W'(1);
    end else if (rx_length > RX_LIM_V) begin
      rx_eff = RX_LIM_V;
    end else begin
      rx_eff = rx_length;
    end
  end

  // frame byte lookup: previous position on a nack, current otherwise
  assign prev_pos   = pos_r - POS_W'(1);
  assign rd_pos     = (action == csi2c_pkg::ACT_TX_READY && nack_seen) ? prev_pos : pos_r;
  assign fbyte      = gsrc_r ? csi2c_pkg::greeting_rom(rd_pos[5:0]) : rd_data;
  assign greet      = (phase_r == csi2c_pkg::PH_GREET_PEND);
  assign lead_byte  = greet ? csi2c_pkg::greeting_rom(6'd0) : pay0;
  assign rx_total   = sum_r + data_byte;

  always_comb begin
    phase_nxt = phase_r;
    after_nxt = after_r;
    pos_nxt   = pos_r;
    flen_nxt  = flen_r;
    sum_nxt   = sum_r;
    dummy_nxt = dummy_r;
    gsrc_nxt  = gsrc_r;
    res       = '0;
    ctl.load_en   = 1'b0;
    ctl.load_idx  = payload_index;
    ctl.load_data = data_byte;
    ctl.snap_en   = 1'b0;
    ctl.rd_idx    = rd_pos[4:0];

    case (action)
      csi2c_pkg::ACT_REQUEST: begin
        if (phase_r == csi2c_pkg::PH_GREET_PEND || phase_r == csi2c_pkg::PH_WRITE_PEND) begin
          gsrc_nxt        = greet;
          flen_nxt        = greet ? GREET_LEN : POS_W'(tx_eff);
          ctl.snap_en     = !greet;
          sum_nxt         = lead_byte;
          res.tx_valid    = 1'b1;
          res.tx_byte     = lead_byte;
          res.start_write = 1'b1;
          res.bus_address = device_address;
          pos_nxt         = POS_W'(1);
          phase_nxt       = csi2c_pkg::PH_WRITING;
          after_nxt       = csi2c_pkg::PH_WRITING;
        end else if (phase_r == csi2c_pkg::PH_READ_PEND) begin
          flen_nxt        = POS_W'(rx_eff);
          pos_nxt         = '0;
          sum_nxt         = 8'h00;
          dummy_nxt       = 1'b1;
          res.start_read  = 1'b1;
          res.bus_address = device_address;
          phase_nxt       = csi2c_pkg::PH_READING;
          after_nxt       = csi2c_pkg::PH_READING;
        end else begin
          phase_nxt = after_r;
        end
      end
      csi2c_pkg::ACT_TX_READY: begin
        if (phase_r == csi2c_pkg::PH_WRITING && after_r == csi2c_pkg::PH_WRITING) begin
          if (nack_seen) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = (prev_pos < flen_r) ? fbyte : ~sum_r;
          end else if (pos_r < flen_r) begin
            sum_nxt      = sum_r + fbyte;
            res.tx_valid = 1'b1;
            res.tx_byte  = fbyte;
            pos_nxt      = pos_r + POS_W'(1);
          end else if (pos_r == flen_r) begin
            res.tx_valid  = 1'b1;
            res.tx_byte   = ~sum_r;
            res.send_stop = 1'b1;
            pos_nxt       = pos_r + POS_W'(1);
          end else begin
            res.frame_done = 1'b1;
            after_nxt      = csi2c_pkg::PH_READ_PEND;
          end
        end
      end
      csi2c_pkg::ACT_RX_BYTE: begin
        if (phase_r == csi2c_pkg::PH_READING && after_r == csi2c_pkg::PH_READING) begin
          if (dummy_r) begin
            dummy_nxt = 1'b0;
          end else if (pos_r < flen_r) begin
            res.rx_valid  = 1'b1;
            res.rx_index  = pos_r[4:0];
            res.rx_byte   = data_byte;
            sum_nxt       = rx_total;
            pos_nxt       = pos_r + POS_W'(1);
            res.send_stop = (pos_r + POS_W'(1)) == flen_r;
          end else begin
            res.frame_done     = 1'b1;
            res.checksum_error = (rx_total != csi2c_pkg::SUM_GOOD);
            after_nxt          = csi2c_pkg::PH_WRITE_PEND;
          end
        end
      end
      csi2c_pkg::ACT_LOAD: begin
        ctl.load_en = 1'b1;
      end
      default: begin
      end
    endcase

    res.phase = phase_nxt;
    if (!fire) begin
      ctl.load_en = 1'b0;
      ctl.snap_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= csi2c_pkg::PH_GREET_PEND;
      after_r <= csi2c_pkg::PH_GREET_PEND;
      pos_r   <= '0;
      flen_r  <= '0;
      sum_r   <= 8'h00;
      dummy_r <= 1'b0;
      gsrc_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      after_r <= after_nxt;
      pos_r   <= pos_nxt;
      flen_r  <= flen_nxt;
      sum_r   <= sum_nxt;
      dummy_r <= dummy_nxt;
      gsrc_r  <= gsrc_nxt;
    end
  end

endmodule
